/* rtl/plt_pkg.sv */
package plt_pkg;

  localparam int NODE_REGS  = 7;
  localparam int IDX_W      = 3;
  localparam int GRAY_W     = 8;
  localparam int CHAN_W     = 9;
  localparam int CH_N       = 4;
  localparam int NODE_W     = 44;
  localparam int OUT_W      = 8;
  // c0*(span-ds) + c1*ds is at most 511*255
  localparam int NUM_W      = 17;
  // the quotient never exceeds the larger channel value, 511
  localparam int Q_W        = 9;
  localparam int DIV_STAGES = 3;
  localparam int BITS_PER   = Q_W / DIV_STAGES;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef logic [GRAY_W-1:0] gray_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [Q_W-1:0]    quo_t;

  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
    gray_t gray;
  } node_t;

  localparam logic [NODE_W-1:0] NODE_RESET [NODE_REGS] = '{
    44'd0, 44'd5197529118, 44'd893353230416, 44'd8813306511615,
    44'd8813306511615, 44'd8813306511615, 44'd8813306511615
  };

  function automatic chan_t node_chan(node_t n, logic [1:0] k);
    chan_t c;
    case (k)
      CH_RED:   c = n.red;
      CH_GREEN: c = n.green;
      CH_BLUE:  c = n.blue;
      CH_ALPHA: c = n.alpha;
      default:  c = n.red;
    endcase
    return c;
  endfunction

endpackage

/* rtl/piecewise_linear_transfer_function.sv */
// Pipeline: five register stages (segment search, weighted sum, three divider
// stages); results are offered on the master side from the last divider stage.
// Throughput: one request per cycle while m_tready is high; the 9-bit quotient
// is resolved three bits per stage, so stalls only back up the pipeline.
// Reset (rst, synchronous): all stage valid bits clear and the node registers
// return to their default transfer curve.
module piecewise_linear_transfer_function #(
  parameter int NODE_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // gray_level[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // red_out, green_out, blue_out, alpha_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [43:0] cfg_data
);

  localparam int LAST   = NODE_COUNT - 1;
  localparam int LAST_D = plt_pkg::DIV_STAGES - 1;

  typedef plt_pkg::chan_t [plt_pkg::CH_N-1:0] chan_vec_t;
  typedef plt_pkg::num_t  [plt_pkg::CH_N-1:0] num_vec_t;
  typedef plt_pkg::quo_t  [plt_pkg::CH_N-1:0] quo_vec_t;

  // node registers
  plt_pkg::node_t nodes [plt_pkg::NODE_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < plt_pkg::NODE_REGS; n++) begin
        nodes[n] <= plt_pkg::node_t'(plt_pkg::NODE_RESET[n]);
      end
    end else if (cfg_valid && (cfg_index < plt_pkg::IDX_W'(plt_pkg::NODE_REGS))) begin
      nodes[cfg_index] <= plt_pkg::node_t'(cfg_data);
    end
  end

  // stage registers
  logic                v1;
  plt_pkg::gray_t      span1, ds1;
  chan_vec_t           c0_1, c1_1;
  logic                v2;
  plt_pkg::gray_t      span2;
  num_vec_t            num2;
  logic                dv    [plt_pkg::DIV_STAGES];
  plt_pkg::gray_t      dspan [plt_pkg::DIV_STAGES];
  num_vec_t            drem  [plt_pkg::DIV_STAGES];
  quo_vec_t            dq    [plt_pkg::DIV_STAGES];

  logic ld1, ld2;
  logic dld [plt_pkg::DIV_STAGES];

  always_comb begin
    dld[LAST_D] = !dv[LAST_D] || m_tready;
    for (int j = LAST_D - 1; j >= 0; j--) begin
      dld[j] = !dv[j] || dld[j+1];
    end
    ld2 = !v2 || dld[0];
    ld1 = !v1 || ld2;
  end

  assign s_tready = ld1;

  // segment search and operand selection
  logic [plt_pkg::IDX_W-1:0] seg, seg_hi;
  logic                      found;
  plt_pkg::gray_t            span_next, ds_next;
  chan_vec_t                 c0_next, c1_next;

  always_comb begin
    found = 1'b0;
    seg   = '0;
    // walk downwards so the lowest matching segment wins
    for (int i = NODE_COUNT - 2; i >= 0; i--) begin
      if ((s_tdata >= nodes[i].gray) && (s_tdata < nodes[i+1].gray)) begin
        found = 1'b1;
        seg   = plt_pkg::IDX_W'(i);
      end
    end
    seg_hi = seg + plt_pkg::IDX_W'(1);
    if (found) begin
      span_next = nodes[seg_hi].gray - nodes[seg].gray;
      ds_next   = s_tdata - nodes[seg].gray;
      for (int k = 0; k < plt_pkg::CH_N; k++) begin
        c0_next[k] = plt_pkg::node_chan(nodes[seg], 2'(k));
        c1_next[k] = plt_pkg::node_chan(nodes[seg_hi], 2'(k));
      end
    end else begin
      // no segment: last node's colour, pushed through as x/1
      span_next = plt_pkg::GRAY_W'(1);
      ds_next   = '0;
      for (int k = 0; k < plt_pkg::CH_N; k++) begin
        c0_next[k] = plt_pkg::node_chan(nodes[LAST], 2'(k));
        c1_next[k] = plt_pkg::node_chan(nodes[LAST], 2'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && s_tvalid) begin
      span1 <= span_next;
      ds1   <= ds_next;
      c0_1  <= c0_next;
      c1_1  <= c1_next;
    end
  end

  // weighted sum
  num_vec_t num_next;

  always_comb begin
    for (int k = 0; k < plt_pkg::CH_N; k++) begin
      num_next[k] = plt_pkg::NUM_W'(c0_1[k]) * plt_pkg::NUM_W'(span1 - ds1)
                  + plt_pkg::NUM_W'(c1_1[k]) * plt_pkg::NUM_W'(ds1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1) begin
      span2 <= span1;
      num2  <= num_next;
    end
  end

  // restoring divider, BITS_PER quotient bits per stage
  logic           src_v    [plt_pkg::DIV_STAGES];
  plt_pkg::gray_t src_span [plt_pkg::DIV_STAGES];
  num_vec_t       src_rem  [plt_pkg::DIV_STAGES];
  quo_vec_t       src_q    [plt_pkg::DIV_STAGES];
  num_vec_t       rem_next [plt_pkg::DIV_STAGES];
  quo_vec_t       q_next   [plt_pkg::DIV_STAGES];

  always_comb begin
    plt_pkg::num_t r, trial;
    plt_pkg::quo_t q;
    int            pos;
    src_v[0]    = v2;
    src_span[0] = span2;
    src_rem[0]  = num2;
    src_q[0]    = '0;
    for (int j = 1; j < plt_pkg::DIV_STAGES; j++) begin
      src_v[j]    = dv[j-1];
      src_span[j] = dspan[j-1];
      src_rem[j]  = drem[j-1];
      src_q[j]    = dq[j-1];
    end
    for (int j = 0; j < plt_pkg::DIV_STAGES; j++) begin
      for (int k = 0; k < plt_pkg::CH_N; k++) begin
        r = src_rem[j][k];
        q = src_q[j][k];
        for (int b = 0; b < plt_pkg::BITS_PER; b++) begin
          pos   = plt_pkg::Q_W - 1 - plt_pkg::BITS_PER * j - b;
          trial = plt_pkg::NUM_W'(src_span[j]) << pos;
          if (r >= trial) begin
            r      = r - trial;
            q[pos] = 1'b1;
          end
        end
        rem_next[j][k] = r;
        q_next[j][k]   = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < plt_pkg::DIV_STAGES; j++) begin
        dv[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < plt_pkg::DIV_STAGES; j++) begin
        if (dld[j]) begin
          dv[j] <= src_v[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < plt_pkg::DIV_STAGES; j++) begin
      if (dld[j] && src_v[j]) begin
        dspan[j] <= src_span[j];
        drem[j]  <= rem_next[j];
        dq[j]    <= q_next[j];
      end
    end
  end

  // saturate to 8 bits
  always_comb begin
    for (int k = 0; k < plt_pkg::CH_N; k++) begin
      if (dq[LAST_D][k] > plt_pkg::Q_W'(255)) begin
        m_tdata[k*plt_pkg::OUT_W +: plt_pkg::OUT_W] = '1;
      end else begin
        m_tdata[k*plt_pkg::OUT_W +: plt_pkg::OUT_W] = dq[LAST_D][k][plt_pkg::OUT_W-1:0];
      end
    end
  end

  assign m_tvalid = dv[LAST_D];

  logic rem_ok;
  always_comb begin
    rem_ok = 1'b1;
    for (int k = 0; k < plt_pkg::CH_N; k++) begin
      if (drem[LAST_D][k] >= plt_pkg::NUM_W'(dspan[LAST_D])) begin
        rem_ok = 1'b0;
      end
    end
  end

  ap_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (span1 != '0))
    else $error("segment span is zero");

  ap_offset_in_span: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (ds1 < span1))
    else $error("gray offset outside its segment");

  ap_divide_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rem_ok)
    else $error("divider remainder not below span");

  ap_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && dv[0] && dv[1] && dv[LAST_D]))
    else $error("input stalled with a bubble in the pipeline");

endmodule

/* test/tb_piecewise_linear_transfer_function.sv */
module tb_piecewise_linear_transfer_function;

  localparam int NODE_COUNT = 7;
  localparam logic [plt_pkg::IDX_W-1:0] STRAY_INDEX = 3'd7;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASES = 8;
  localparam int REPORT_CAP = 40;

  typedef logic [plt_pkg::NODE_W-1:0] node_word_t;

  // red in the low byte, as on m_tdata
  typedef struct packed {
    logic [plt_pkg::OUT_W-1:0] alpha;
    logic [plt_pkg::OUT_W-1:0] blue;
    logic [plt_pkg::OUT_W-1:0] green;
    logic [plt_pkg::OUT_W-1:0] red;
  } rgba_t;

  typedef struct {
    plt_pkg::gray_t gray;
    rgba_t rgba;
  } pixel_t;

  class rgba_ledger;
    node_word_t curve [plt_pkg::NODE_REGS];
    pixel_t pending [$];
    int mismatches;
    int checked;

    function new();
      foreach (curve[n]) curve[n] = plt_pkg::NODE_RESET[n];
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_node(logic [plt_pkg::IDX_W-1:0] idx, node_word_t val);
      if (idx < plt_pkg::NODE_REGS) curve[idx] = val;
    endfunction

    // first segment with gray[i] <= s < gray[i+1]; otherwise the last node
    function rgba_t lookup_rgba(plt_pkg::gray_t s);
      rgba_t px;
      logic [plt_pkg::OUT_W-1:0] ch [plt_pkg::CH_N];
      int seg, g0, span, ds, c0, c1, v;
      bit hit;
      hit = 1'b0;
      seg = 0;
      for (int i = 0; i + 1 < NODE_COUNT; i++) begin
        if (!hit && s >= curve[i][plt_pkg::GRAY_W-1:0] &&
            s < curve[i+1][plt_pkg::GRAY_W-1:0]) begin
          seg = i;
          hit = 1'b1;
        end
      end
      for (int k = 0; k < plt_pkg::CH_N; k++) begin
        if (hit) begin
          g0   = int'(curve[seg][plt_pkg::GRAY_W-1:0]);
          span = int'(curve[seg+1][plt_pkg::GRAY_W-1:0]) - g0;
          ds   = int'(s) - g0;
          c0   = int'(curve[seg][plt_pkg::GRAY_W+plt_pkg::CHAN_W*k +:
                                 plt_pkg::CHAN_W]);
          c1   = int'(curve[seg+1][plt_pkg::GRAY_W+plt_pkg::CHAN_W*k +:
                                   plt_pkg::CHAN_W]);
          v    = (c0 * (span - ds) + c1 * ds) / span;
        end else begin
          v = int'(curve[NODE_COUNT-1][plt_pkg::GRAY_W+plt_pkg::CHAN_W*k +:
                                       plt_pkg::CHAN_W]);
        end
        ch[k] = (v > 255) ? 8'd255 : v[plt_pkg::OUT_W-1:0];
      end
      px = {ch[3], ch[2], ch[1], ch[0]};
      return px;
    endfunction

    function void note_gray(plt_pkg::gray_t s);
      pixel_t p;
      p.gray = s;
      p.rgba = lookup_rgba(s);
      pending.push_back(p);
    endfunction

    task report_mismatch(string what);
      if (mismatches < REPORT_CAP) $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_pixel(rgba_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.red !== want.rgba.red || got.green !== want.rgba.green ||
          got.blue !== want.rgba.blue || got.alpha !== want.rgba.alpha)
        report_mismatch($sformatf("gray %0d: got r%0d g%0d b%0d a%0d, want r%0d g%0d b%0d a%0d",
                                  want.gray, got.red, got.green, got.blue, got.alpha,
                                  want.rgba.red, want.rgba.green, want.rgba.blue,
                                  want.rgba.alpha));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata = '0;     // gray_level[7:0]
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [31:0]                m_tdata;  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [plt_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [plt_pkg::NODE_W-1:0] cfg_data = '0;

  rgba_ledger ledger;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int grays_sent = 0;
  int node_writes = 0;
  int curves_used = 1;

  piecewise_linear_transfer_function #(
    .NODE_COUNT(NODE_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.write_node(cfg_index, cfg_data);
      if (s_tvalid && s_tready) ledger.note_gray(s_tdata);
      if (m_tvalid && m_tready) ledger.check_pixel(m_tdata);
    end
  end

  function automatic node_word_t pack_node(int g, int r, int gr, int b, int a);
    plt_pkg::node_t n;
    n.gray  = g[plt_pkg::GRAY_W-1:0];
    n.red   = r[plt_pkg::CHAN_W-1:0];
    n.green = gr[plt_pkg::CHAN_W-1:0];
    n.blue  = b[plt_pkg::CHAN_W-1:0];
    n.alpha = a[plt_pkg::CHAN_W-1:0];
    return n;
  endfunction

  function automatic int pick_chan();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 511;
      2:       return 256;
      3:       return 255;
      default: return $urandom_range(511);
    endcase
  endfunction

  // mostly ascending curves; a quarter left unsorted
  function automatic void random_curve(output node_word_t c [plt_pkg::NODE_REGS]);
    node_word_t t;
    for (int n = 0; n < plt_pkg::NODE_REGS; n++)
      c[n] = pack_node($urandom_range(255), pick_chan(), pick_chan(), pick_chan(),
                       pick_chan());
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < plt_pkg::NODE_REGS - 1; i++)
        for (int j = 0; j < plt_pkg::NODE_REGS - 1 - i; j++)
          if (c[j][plt_pkg::GRAY_W-1:0] > c[j+1][plt_pkg::GRAY_W-1:0]) begin
            t = c[j];
            c[j] = c[j+1];
            c[j+1] = t;
          end
      if ($urandom_range(1) == 1) c[0][plt_pkg::GRAY_W-1:0] = '0;
    end
  endfunction

  function automatic plt_pkg::gray_t pick_gray();
    plt_pkg::gray_t g;
    if ($urandom_range(9) < 7) return plt_pkg::gray_t'($urandom_range(255));
    g = ledger.curve[$urandom_range(plt_pkg::NODE_REGS-1)][plt_pkg::GRAY_W-1:0];
    return g + plt_pkg::gray_t'($urandom_range(2)) - 8'd1;
  endfunction

  task automatic send_gray(plt_pkg::gray_t s);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    do @(posedge clk); while (!s_tready);
    grays_sent++;
  endtask

  // stop requests and let the pipeline empty before touching the nodes
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_curve(node_word_t c [plt_pkg::NODE_REGS], bit stray);
    for (int n = 0; n < plt_pkg::NODE_REGS + int'(stray); n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (n < plt_pkg::NODE_REGS) ? plt_pkg::IDX_W'(n) : STRAY_INDEX;
      cfg_data  <= (n < plt_pkg::NODE_REGS) ? c[n] : node_word_t'({$urandom, $urandom});
      do @(posedge clk); while (!cfg_ready);
      node_writes++;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    curves_used++;
  endtask

  initial begin
    node_word_t c [plt_pkg::NODE_REGS];
    plt_pkg::gray_t reset_grays [$];
    plt_pkg::gray_t odd_grays [$];
    ledger = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 26;
    rx_idle_pct = 52;

    // default curve: segment edges and the top value that no segment covers
    reset_grays = '{8'd0, 8'd1, 8'd29, 8'd30, 8'd31, 8'd79, 8'd80, 8'd81, 8'd170, 8'd254,
                    8'd255};
    foreach (reset_grays[i]) send_gray(reset_grays[i]);
    settle();

    // gap below node 0, empty span, a node out of order, saturation, empty tail
    c[0] = pack_node(10, 511, 0, 256, 300);
    c[1] = pack_node(20, 0, 511, 255, 300);
    c[2] = pack_node(20, 100, 100, 100, 100);
    c[3] = pack_node(5, 1, 2, 3, 4);
    c[4] = pack_node(200, 511, 511, 511, 511);
    c[5] = pack_node(254, 0, 256, 511, 128);
    c[6] = pack_node(254, 300, 0, 255, 256);
    load_curve(c, 1'b1);
    odd_grays = '{8'd0, 8'd4, 8'd5, 8'd9, 8'd10, 8'd15, 8'd19, 8'd20, 8'd100, 8'd199,
                  8'd200, 8'd253, 8'd254, 8'd255};
    foreach (odd_grays[i]) send_gray(odd_grays[i]);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       foreach (c[n]) c[n] = '0;
        1:       foreach (c[n]) c[n] = '1;
        default: random_curve(c);
      endcase
      load_curve(c, $urandom_range(3) == 0);
      if (p < 3) begin
        tx_idle_pct = 26;
        rx_idle_pct = 52;
      end else if (p < 6) begin
        tx_idle_pct = 52;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_gray(pick_gray());
    end

    settle();
    $display("Mapped %0d gray levels through %0d transfer curves (%0d node writes).",
             grays_sent, curves_used, node_writes);
    $display("%0d pixels compared, %0d mismatches.", ledger.checked, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out waiting for the pipeline.");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/plt_pkg.sv
rtl/piecewise_linear_transfer_function.sv
test/tb_piecewise_linear_transfer_function.sv
